@@ rtl/ptw_pkg.sv @@
// ptw_pkg: geometry constants, types, datapath command codes and the level index helper
// depends on nothing; imported by every module of the page table walker except ptw_ram
`timescale 1ns / 1ps
package ptw_pkg;

    localparam int OFFSET_BITS  = 4;
    localparam int VADDR_BITS   = 12;
    localparam int FRAME_COUNT  = 16;
    localparam int TABLE_LEVELS = 2;
    localparam int WORD_BITS    = 32;

    localparam int PAGE_WORDS  = 1 << OFFSET_BITS;
    localparam int PAGE_BITS   = VADDR_BITS - OFFSET_BITS;
    localparam int PAGE_COUNT  = 1 << PAGE_BITS;
    localparam int FRAME_BITS  = $clog2(FRAME_COUNT);
    localparam int PHYS_WORDS  = FRAME_COUNT * PAGE_WORDS;
    localparam int PHYS_ABITS  = $clog2(PHYS_WORDS);
    localparam int SWAP_WORDS  = 1 << VADDR_BITS;
    localparam int SWAP_ABITS  = VADDR_BITS;
    localparam int LVL_BITS    = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;
    localparam int SP_BITS     = $clog2(TABLE_LEVELS + 1);
    localparam int TOP_BITS    = (PAGE_BITS % OFFSET_BITS == 0) ? OFFSET_BITS
                                                               : PAGE_BITS % OFFSET_BITS;
    localparam int IN_VADDR_W  = 13;

    typedef logic [FRAME_BITS-1:0]  t_frame;
    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [OFFSET_BITS:0]   t_idx;
    typedef logic [PAGE_BITS-1:0]   t_page;
    typedef logic [PAGE_BITS:0]     t_dist;
    typedef logic [PHYS_ABITS-1:0]  t_paddr;
    typedef logic [SWAP_ABITS-1:0]  t_saddr;
    typedef logic [WORD_BITS-1:0]   t_word;
    typedef logic [SP_BITS-1:0]     t_sp;
    typedef logic [LVL_BITS-1:0]    t_lvl;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_T_INIT,
        OP_T_RD,
        OP_T_CHK,
        OP_T_NEXT,
        OP_W_INIT,
        OP_W_VISIT,
        OP_W_RD,
        OP_W_CHK,
        OP_W_POP,
        OP_P_SEL,
        OP_P_CLR,
        OP_EV_RD,
        OP_EV_WR,
        OP_ZERO,
        OP_FL_RD,
        OP_FL_WR,
        OP_T_LINK,
        OP_ACC_WR,
        OP_ACC_RD,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_WR,
        RES_RD
    } t_res;

    typedef enum logic [1:0] {
        SEL_NEXT,
        SEL_EMPTY,
        SEL_LEAF,
        SEL_NONE
    } t_sel;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_CHECK,
        S_T_RD,
        S_T_CHK,
        S_T_NEXT,
        S_W_INIT,
        S_W_VISIT,
        S_W_RD,
        S_W_CHK,
        S_W_POP,
        S_P_SEL,
        S_P_CLR,
        S_EV_RD,
        S_EV_WR,
        S_ZERO,
        S_FL_RD,
        S_FL_WR,
        S_T_LINK,
        S_ACC_WR,
        S_ACC_RD,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op  op;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic rd_nz;
        logic at_leaf;
        logic idx_end;
        logic sp_zero;
        logic lvl_last;
        t_sel sel;
        logic cnt_last;
        logic clr_last;
        logic out_free;
        logic func;
        logic oor;
    } t_sts;

    // right shift that brings the index of table level d to the bottom of the page number
    function automatic int lvl_shift(input t_lvl d);
        int used;
        used = TOP_BITS + int'(d) * OFFSET_BITS;
        return (used > PAGE_BITS) ? 0 : PAGE_BITS - used;
    endfunction

endpackage

@@ rtl/ptw_ram.sv @@
// ptw_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps
module ptw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/ptw_ctrl.sv @@
// ptw_ctrl: state machine that sequences clearing, translation, tree search and page moves
// depends on ptw_pkg; drives the datapath by one command a cycle
`timescale 1ns / 1ps
module ptw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ptw_pkg::t_sts i_sts,
    output ptw_pkg::t_cmd o_cmd
);
    import ptw_pkg::*;

    t_state r_state, n_state;
    t_res   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_res   <= RES_FAIL;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        o_cmd.op   = OP_NONE;
        o_cmd.res  = r_res;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.oor) begin
                    n_res   = RES_FAIL;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.op = OP_T_INIT;
                    n_state  = S_T_RD;
                end
            end
            S_T_RD: begin
                o_cmd.op = OP_T_RD;
                n_state  = S_T_CHK;
            end
            S_T_CHK: begin
                o_cmd.op = OP_T_CHK;
                n_state  = i_sts.rd_nz ? S_T_NEXT : S_W_INIT;
            end
            S_T_NEXT: begin
                o_cmd.op = OP_T_NEXT;
                if (!i_sts.lvl_last) n_state = S_T_RD;
                else n_state = i_sts.func ? S_ACC_WR : S_ACC_RD;
            end
            S_W_INIT: begin
                o_cmd.op = OP_W_INIT;
                n_state  = S_W_VISIT;
            end
            S_W_VISIT: begin
                o_cmd.op = OP_W_VISIT;
                n_state  = i_sts.at_leaf ? S_W_POP : S_W_RD;
            end
            S_W_RD: begin
                if (i_sts.idx_end) begin
                    n_state = S_W_POP;
                end else begin
                    o_cmd.op = OP_W_RD;
                    n_state  = S_W_CHK;
                end
            end
            S_W_CHK: begin
                o_cmd.op = OP_W_CHK;
                n_state  = i_sts.rd_nz ? S_W_VISIT : S_W_RD;
            end
            S_W_POP: begin
                o_cmd.op = OP_W_POP;
                n_state  = i_sts.sp_zero ? S_P_SEL : S_W_RD;
            end
            S_P_SEL: begin
                o_cmd.op = OP_P_SEL;
                unique case (i_sts.sel)
                    SEL_NEXT:  n_state = i_sts.lvl_last ? S_FL_RD : S_ZERO;
                    SEL_EMPTY: n_state = S_P_CLR;
                    SEL_LEAF:  n_state = S_EV_RD;
                    default: begin
                        n_res   = RES_FAIL;
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_EV_RD: begin
                o_cmd.op = OP_EV_RD;
                n_state  = S_EV_WR;
            end
            S_EV_WR: begin
                o_cmd.op = OP_EV_WR;
                n_state  = i_sts.cnt_last ? S_P_CLR : S_EV_RD;
            end
            S_P_CLR: begin
                o_cmd.op = OP_P_CLR;
                n_state  = i_sts.lvl_last ? S_FL_RD : S_ZERO;
            end
            S_ZERO: begin
                o_cmd.op = OP_ZERO;
                if (i_sts.cnt_last) n_state = S_T_LINK;
            end
            S_FL_RD: begin
                o_cmd.op = OP_FL_RD;
                n_state  = S_FL_WR;
            end
            S_FL_WR: begin
                o_cmd.op = OP_FL_WR;
                n_state  = i_sts.cnt_last ? S_T_LINK : S_FL_RD;
            end
            S_T_LINK: begin
                o_cmd.op = OP_T_LINK;
                n_state  = S_T_NEXT;
            end
            S_ACC_WR: begin
                o_cmd.op = OP_ACC_WR;
                n_res    = RES_WR;
                n_state  = S_EMIT;
            end
            S_ACC_RD: begin
                o_cmd.op = OP_ACC_RD;
                n_res    = RES_RD;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end
endmodule

@@ rtl/ptw_dp.sv @@
// ptw_dp: word stores, walk stack, search results and output register
// depends on ptw_pkg and ptw_ram; executes one command from ptw_ctrl per cycle
`timescale 1ns / 1ps
module ptw_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptw_pkg::t_cmd                     i_cmd,
    output ptw_pkg::t_sts                     o_sts,
    input  logic                              i_in_func,
    input  logic [ptw_pkg::IN_VADDR_W-1:0]    i_in_vaddr,
    input  logic signed [31:0]                i_in_write_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_out_ok,
    output logic signed [31:0]                o_out_read_data
);
    import ptw_pkg::*;

    // captured word
    logic                  r_func;
    logic [IN_VADDR_W-1:0] r_vaddr;
    t_word                 r_wd;

    // translation
    t_frame r_t_frame;
    t_lvl   r_lvl;
    t_paddr r_t_addr;
    t_frame r_path [TABLE_LEVELS];
    t_sp    r_path_len;

    // walk stack, one slot per depth including the page level
    t_frame r_stk_frame  [TABLE_LEVELS+1];
    t_idx   r_stk_idx    [TABLE_LEVELS+1];
    t_page  r_stk_prefix [TABLE_LEVELS+1];
    t_paddr r_stk_parent [TABLE_LEVELS+1];
    logic   r_stk_empty  [TABLE_LEVELS+1];
    logic   r_stk_barred [TABLE_LEVELS+1];
    t_sp    r_sp;

    // search results
    t_frame r_max;
    logic   r_empty_ok;
    t_frame r_empty_frame;
    t_paddr r_empty_parent;
    logic   r_leaf_ok;
    t_frame r_leaf_frame;
    t_page  r_leaf_page;
    t_paddr r_leaf_parent;
    t_dist  r_leaf_dist;
    t_frame r_f;
    t_sel   r_sel;

    t_off   r_cnt;
    t_saddr r_clr;

    logic   r_out_valid;
    logic   r_out_ok;
    t_word  r_out_data;

    // ram ports
    logic   pm_we, pm_re, sw_we, sw_re;
    t_paddr pm_waddr, pm_raddr;
    t_word  pm_wdata, pm_rdata, sw_wdata, sw_rdata;
    t_saddr sw_waddr, sw_raddr;

    t_page  page;
    t_off   lvl_idx;
    t_frame cur_frame;
    t_paddr walk_addr;
    logic   barred;
    t_page  dlt;
    t_dist  ring_d, other;
    logic   better;
    t_sel   sel;
    logic   out_take;

    ptw_ram #(.WIDTH(WORD_BITS), .DEPTH(PHYS_WORDS)) u_phys (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_re    (pm_re),
        .i_raddr (pm_raddr),
        .o_rdata (pm_rdata)
    );

    ptw_ram #(.WIDTH(WORD_BITS), .DEPTH(SWAP_WORDS)) u_swap (
        .i_clk   (i_clk),
        .i_we    (sw_we),
        .i_waddr (sw_waddr),
        .i_wdata (sw_wdata),
        .i_re    (sw_re),
        .i_raddr (sw_raddr),
        .o_rdata (sw_rdata)
    );

    assign page      = r_vaddr[VADDR_BITS-1:OFFSET_BITS];
    assign lvl_idx   = t_off'(page >> lvl_shift(r_lvl));
    assign cur_frame = r_stk_frame[r_sp];
    assign walk_addr = {cur_frame, r_stk_idx[r_sp][OFFSET_BITS-1:0]};

    always_comb begin
        barred = 1'b0;
        for (int i = 0; i < TABLE_LEVELS; i++) begin
            if (t_sp'(i) < r_path_len && r_path[i] == cur_frame) barred = 1'b1;
        end
    end

    // cyclic distance between the visited page and the target page
    always_comb begin
        dlt    = (r_stk_prefix[r_sp] > page) ? r_stk_prefix[r_sp] - page
                                             : page - r_stk_prefix[r_sp];
        other  = t_dist'(PAGE_COUNT) - t_dist'(dlt);
        ring_d = (other < t_dist'(dlt)) ? other : t_dist'(dlt);
        better = !r_leaf_ok || ring_d > r_leaf_dist
                 || (ring_d == r_leaf_dist && r_stk_prefix[r_sp] < r_leaf_page);
    end

    always_comb begin
        if (r_max != t_frame'(FRAME_COUNT - 1)) sel = SEL_NEXT;
        else if (r_empty_ok) sel = SEL_EMPTY;
        else if (r_leaf_ok) sel = SEL_LEAF;
        else sel = SEL_NONE;
    end

    always_comb begin
        pm_we    = 1'b0;
        pm_waddr = '0;
        pm_wdata = '0;
        pm_re    = 1'b0;
        pm_raddr = '0;
        sw_we    = 1'b0;
        sw_waddr = '0;
        sw_wdata = '0;
        sw_re    = 1'b0;
        sw_raddr = '0;
        unique case (i_cmd.op)
            OP_CLR: begin
                pm_we    = 1'b1;
                pm_waddr = t_paddr'(r_clr);
                sw_we    = 1'b1;
                sw_waddr = r_clr;
            end
            OP_T_RD: begin
                pm_re    = 1'b1;
                pm_raddr = {r_t_frame, lvl_idx};
            end
            OP_W_RD: begin
                pm_re    = 1'b1;
                pm_raddr = walk_addr;
            end
            OP_P_CLR: begin
                pm_we    = 1'b1;
                pm_waddr = (r_sel == SEL_EMPTY) ? r_empty_parent : r_leaf_parent;
            end
            OP_EV_RD: begin
                pm_re    = 1'b1;
                pm_raddr = {r_f, r_cnt};
            end
            OP_EV_WR: begin
                sw_we    = 1'b1;
                sw_waddr = {r_leaf_page, r_cnt};
                sw_wdata = pm_rdata;
            end
            OP_ZERO: begin
                pm_we    = 1'b1;
                pm_waddr = {r_f, r_cnt};
            end
            OP_FL_RD: begin
                sw_re    = 1'b1;
                sw_raddr = {page, r_cnt};
            end
            OP_FL_WR: begin
                pm_we    = 1'b1;
                pm_waddr = {r_f, r_cnt};
                pm_wdata = sw_rdata;
            end
            OP_T_LINK: begin
                pm_we    = 1'b1;
                pm_waddr = r_t_addr;
                pm_wdata = t_word'(r_f);
            end
            OP_ACC_WR: begin
                pm_we    = 1'b1;
                pm_waddr = {r_t_frame, r_vaddr[OFFSET_BITS-1:0]};
                pm_wdata = r_wd;
            end
            OP_ACC_RD: begin
                pm_re    = 1'b1;
                pm_raddr = {r_t_frame, r_vaddr[OFFSET_BITS-1:0]};
            end
            default: ;
        endcase
    end

    assign out_take = r_out_valid && !i_out_stall;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CLR) r_clr <= r_clr + 1'b1;
            if (i_cmd.op == OP_EMIT) r_out_valid <= 1'b1;
            else if (out_take) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_func  <= i_in_func;
                r_vaddr <= i_in_vaddr;
                r_wd    <= i_in_write_data;
            end
            OP_T_INIT: begin
                r_t_frame  <= '0;
                r_lvl      <= '0;
                r_path[0]  <= '0;
                r_path_len <= t_sp'(1);
            end
            OP_T_RD: r_t_addr <= {r_t_frame, lvl_idx};
            OP_T_CHK: r_t_frame <= pm_rdata[FRAME_BITS-1:0];
            OP_T_NEXT: begin
                if (int'(r_lvl) + 1 < TABLE_LEVELS) begin
                    r_path[int'(r_lvl) + 1] <= r_t_frame;
                    r_path_len              <= t_sp'(int'(r_lvl) + 2);
                    r_lvl                   <= r_lvl + 1'b1;
                end
            end
            OP_W_INIT: begin
                r_max           <= '0;
                r_empty_ok      <= 1'b0;
                r_leaf_ok       <= 1'b0;
                r_leaf_dist     <= '0;
                r_sp            <= '0;
                r_stk_frame[0]  <= '0;
                r_stk_prefix[0] <= '0;
                r_stk_parent[0] <= '0;
            end
            OP_W_VISIT: begin
                if (cur_frame > r_max) r_max <= cur_frame;
                if (r_sp == t_sp'(TABLE_LEVELS)) begin
                    if (!barred && better) begin
                        r_leaf_ok     <= 1'b1;
                        r_leaf_dist   <= ring_d;
                        r_leaf_frame  <= cur_frame;
                        r_leaf_page   <= r_stk_prefix[r_sp];
                        r_leaf_parent <= r_stk_parent[r_sp];
                    end
                end else begin
                    r_stk_idx[r_sp]    <= '0;
                    r_stk_empty[r_sp]  <= 1'b1;
                    r_stk_barred[r_sp] <= barred;
                end
            end
            OP_W_CHK: begin
                r_stk_idx[r_sp] <= r_stk_idx[r_sp] + 1'b1;
                if (pm_rdata != '0) begin
                    r_stk_empty[r_sp]       <= 1'b0;
                    r_stk_frame[r_sp + 1'b1]  <= pm_rdata[FRAME_BITS-1:0];
                    r_stk_prefix[r_sp + 1'b1] <=
                        t_page'({r_stk_prefix[r_sp], r_stk_idx[r_sp][OFFSET_BITS-1:0]});
                    r_stk_parent[r_sp + 1'b1] <= walk_addr;
                    r_sp                    <= r_sp + 1'b1;
                end
            end
            OP_W_POP: begin
                if (r_sp != t_sp'(TABLE_LEVELS) && r_stk_empty[r_sp]
                    && !r_stk_barred[r_sp] && !r_empty_ok) begin
                    r_empty_ok     <= 1'b1;
                    r_empty_frame  <= cur_frame;
                    r_empty_parent <= r_stk_parent[r_sp];
                end
                if (r_sp != '0) r_sp <= r_sp - 1'b1;
            end
            OP_P_SEL: begin
                r_sel <= sel;
                r_cnt <= '0;
                unique case (sel)
                    SEL_NEXT:  r_f <= r_max + 1'b1;
                    SEL_EMPTY: r_f <= r_empty_frame;
                    default:   r_f <= r_leaf_frame;
                endcase
            end
            OP_EV_WR, OP_ZERO, OP_FL_WR: r_cnt <= r_cnt + 1'b1;
            OP_T_LINK: r_t_frame <= r_f;
            OP_EMIT: begin
                r_out_ok   <= (i_cmd.res != RES_FAIL);
                r_out_data <= (i_cmd.res == RES_RD) ? pm_rdata : '0;
            end
            default: ;
        endcase
    end

    assign o_sts.rd_nz    = (pm_rdata != '0);
    assign o_sts.at_leaf  = (r_sp == t_sp'(TABLE_LEVELS));
    assign o_sts.idx_end  = r_stk_idx[r_sp][OFFSET_BITS];
    assign o_sts.sp_zero  = (r_sp == '0);
    assign o_sts.lvl_last = (int'(r_lvl) == TABLE_LEVELS - 1);
    assign o_sts.sel      = sel;
    assign o_sts.cnt_last = (r_cnt == t_off'(PAGE_WORDS - 1));
    assign o_sts.clr_last = (r_clr == t_saddr'(SWAP_WORDS - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.func     = r_func;
    assign o_sts.oor      = (r_vaddr >= IN_VADDR_W'(SWAP_WORDS));

    assign o_out_valid     = r_out_valid;
    assign o_out_ok        = r_out_ok;
    assign o_out_read_data = r_out_data;
endmodule

@@ rtl/page_table_walker_with_eviction_top.sv @@
// page_table_walker_with_eviction_top: top level of the two-level page table walker
// depends on ptw_pkg, ptw_ctrl, ptw_dp (which holds the ptw_ram stores)
`timescale 1ns / 1ps
// each input word is one read or write at a virtual word address; each gives exactly one
// result word (ok flag and read data). after reset the block clears the physical store
// (256 words) and the swap store (4096 words, one slot per virtual word) and takes no
// input word during that pass. a hit runs the range check, then a read, a check and a step
// for each table level, then the access and the result. a miss runs a depth first search
// over every table reachable from the root frame, reading each table entry and visiting
// each node; a page fetch from swap, an eviction to swap and the zeroing of a new table
// frame add to that. addresses at or above 4096 are refused with ok low. one word is worked
// on at a time; a finished result sits in an output register, so the next word can be
// taken while the result waits to be taken.
module page_table_walker_with_eviction_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_in_func,
    input  logic [ptw_pkg::IN_VADDR_W-1:0] i_in_vaddr,
    input  logic signed [31:0]             i_in_write_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_out_ok,
    output logic signed [31:0]             o_out_read_data
);
    import ptw_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: clearing pass, translation, search, page moves, result
    ptw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // stores, walk stack and output register
    ptw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_func       (i_in_func),
        .i_in_vaddr      (i_in_vaddr),
        .i_in_write_data (i_in_write_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_ok        (o_out_ok),
        .o_out_read_data (o_out_read_data)
    );
endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking bench for page_table_walker_with_eviction_top, directed and random read/write words
// with an in-bench page table predictor; depends on ptw_pkg and the rtl of the walker
`timescale 1ns / 1ps
module tb_top;
    import ptw_pkg::*;

    localparam logic FN_READ  = 1'b0;
    localparam logic FN_WRITE = 1'b1;

    typedef struct {
        logic        func;
        logic [12:0] vaddr;
        logic [31:0] wdata;
    } t_access;

    typedef struct {
        logic        ok;
        logic [31:0] rdata;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_in_func = 1'b0;
    logic [12:0] i_in_vaddr = '0;
    logic signed [31:0] i_in_write_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_out_ok;
    logic signed [31:0] o_out_read_data;

    page_table_walker_with_eviction_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_in_func(i_in_func), .i_in_vaddr(i_in_vaddr), .i_in_write_data(i_in_write_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_ok(o_out_ok), .o_out_read_data(o_out_read_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: physical frames and swap image
    logic [31:0] mem_img [PHYS_WORDS];
    logic [31:0] swap_img [SWAP_WORDS];
    int unsigned walk_path [TABLE_LEVELS];
    int unsigned walk_path_len;

    // depth first search results
    int unsigned top_frame;
    bit          have_empty;
    int unsigned empty_frm, empty_par;
    bit          have_leaf;
    int unsigned leaf_frm, leaf_pg, leaf_par, leaf_dist;

    t_access pending_words[$];
    t_reply  expected_replies[$];
    int      fail_count = 0;
    bit      stim_done = 1'b0;
    int      hold_off = 0;
    bit      calm = 1'b0;

    function automatic int unsigned cyc_dist(int unsigned a, int unsigned b);
        int unsigned d, o;
        d = (a > b) ? a - b : b - a;
        o = PAGE_COUNT - d;
        return (o < d) ? o : d;
    endfunction

    function automatic bit in_path(int unsigned f);
        for (int i = 0; i < walk_path_len && i < TABLE_LEVELS; i++)
            if (walk_path[i] == f) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void visit(int unsigned frm, int unsigned depth, int unsigned pfx,
                                  int unsigned parent, int unsigned target);
        bit barred, empty;
        int unsigned a, d;
        logic [31:0] child;
        frm = frm % FRAME_COUNT;
        if (frm > top_frame) top_frame = frm;
        barred = in_path(frm);
        if (depth >= TABLE_LEVELS) begin
            if (!barred) begin
                d = cyc_dist(pfx, target);
                if (!have_leaf || d > leaf_dist || (d == leaf_dist && pfx < leaf_pg)) begin
                    have_leaf = 1'b1;
                    leaf_dist = d;
                    leaf_frm = frm;
                    leaf_pg = pfx;
                    leaf_par = parent;
                end
            end
            return;
        end
        empty = 1'b1;
        for (int i = 0; i < PAGE_WORDS; i++) begin
            a = frm * PAGE_WORDS + i;
            child = mem_img[a];
            if (child == 0) continue;
            empty = 1'b0;
            visit(child, depth + 1, ((pfx << OFFSET_BITS) | i) & (PAGE_COUNT - 1), a, target);
        end
        if (empty && !barred && !have_empty) begin
            have_empty = 1'b1;
            empty_frm = frm;
            empty_par = parent;
        end
    endfunction

    // find a frame for the missing level; evicts to swap when the store is full and no empty table can be reused
    function automatic bit claim_frame(int unsigned target, bit as_table, output int unsigned f);
        top_frame = 0;
        have_empty = 0; have_leaf = 0;
        empty_frm = 0; empty_par = 0;
        leaf_frm = 0; leaf_pg = 0; leaf_par = 0; leaf_dist = 0;
        visit(0, 0, 0, 0, target);
        f = 0;
        if (top_frame + 1 < FRAME_COUNT) begin
            f = top_frame + 1;
        end else if (have_empty) begin
            f = empty_frm;
            mem_img[empty_par % PHYS_WORDS] = 0;
        end else if (have_leaf) begin
            f = leaf_frm;
            for (int i = 0; i < PAGE_WORDS; i++)
                swap_img[(leaf_pg * PAGE_WORDS + i) % SWAP_WORDS] = mem_img[f * PAGE_WORDS + i];
            mem_img[leaf_par % PHYS_WORDS] = 0;
        end else begin
            return 1'b0;
        end
        if (as_table)
            for (int i = 0; i < PAGE_WORDS; i++) mem_img[f * PAGE_WORDS + i] = 0;
        return 1'b1;
    endfunction

    function automatic t_reply predict_access(t_access w);
        t_reply r;
        int unsigned pg, frm, idx, a, nf, shift, used;
        bit is_tbl;
        r.ok = 1'b0;
        r.rdata = '0;
        if (w.vaddr >= SWAP_WORDS) return r;
        pg = w.vaddr >> OFFSET_BITS;
        frm = 0;
        walk_path[0] = 0;
        walk_path_len = 1;
        for (int d = 0; d < TABLE_LEVELS; d++) begin
            used = TOP_BITS + d * OFFSET_BITS;
            shift = (used > PAGE_BITS) ? 0 : PAGE_BITS - used;
            idx = (pg >> shift) & (PAGE_WORDS - 1);
            a = frm * PAGE_WORDS + idx;
            nf = mem_img[a] % FRAME_COUNT;
            if (mem_img[a] == 0) begin
                is_tbl = (d + 1 < TABLE_LEVELS);
                if (!claim_frame(pg, is_tbl, nf)) return r;
                if (!is_tbl)
                    for (int i = 0; i < PAGE_WORDS; i++)
                        mem_img[nf * PAGE_WORDS + i] =
                            swap_img[(pg * PAGE_WORDS + i) % SWAP_WORDS];
                mem_img[a] = nf;
            end
            frm = nf;
            if (d + 1 < TABLE_LEVELS) begin
                walk_path[d + 1] = frm;
                walk_path_len = d + 2;
            end
        end
        a = frm * PAGE_WORDS + (w.vaddr & (PAGE_WORDS - 1));
        if (w.func == FN_WRITE) mem_img[a] = w.wdata;
        else r.rdata = mem_img[a];
        r.ok = 1'b1;
        return r;
    endfunction

    // stimulus: fill the queue of pending words
    function automatic void push_word(logic fn, logic [12:0] va, logic [31:0] wd);
        t_access w;
        w.func = fn;
        w.vaddr = va;
        w.wdata = wd;
        pending_words.push_back(w);
    endfunction

    initial begin
        logic [12:0] va;
        int unsigned hot_pg;
        foreach (mem_img[i]) mem_img[i] = '0;
        foreach (swap_img[i]) swap_img[i] = '0;
        // directed: never written page, extremes, refused addresses
        push_word(FN_READ, 13'd0, 32'hFFFF_FFFF);
        push_word(FN_WRITE, 13'd0, 32'h8000_0000);
        push_word(FN_READ, 13'd0, 32'd0);
        push_word(FN_WRITE, 13'd4095, 32'h7FFF_FFFF);
        push_word(FN_READ, 13'd4095, 32'd0);
        push_word(FN_READ, 13'd4096, 32'd0);
        push_word(FN_WRITE, 13'd8191, 32'hFFFF_FFFF);
        push_word(FN_READ, 13'd5000, 32'h1234_5678);
        push_word(FN_WRITE, 13'h0AAA, 32'h5555_AAAA);
        push_word(FN_WRITE, 13'h0555, 32'hAAAA_5555);
        push_word(FN_READ, 13'h0AAA, 32'd0);
        push_word(FN_READ, 13'h0555, 32'd0);
        // touch many pages in distinct tables to force empty-table reuse and eviction
        for (int i = 0; i < 13; i++)
            push_word(FN_WRITE, 13'((i * 37 % 16) * 256 + (i * 16) % 256 + i), $urandom);
        // random: mostly a hot set of pages so hits, fetches and evictions all show up
        hot_pg = $urandom_range(0, 255);
        for (int i = 0; i < 1150; i++) begin
            case ($urandom_range(0, 9))
                0: va = 13'($urandom_range(4096, 8191));
                1, 2: va = 13'($urandom_range(0, 4095));
                default: va = 13'((((hot_pg + $urandom_range(0, 40)) % 256) << 4)
                                  | $urandom_range(0, 15));
            endcase
            if ($urandom_range(0, 99) == 0) hot_pg = $urandom_range(0, 255);
            push_word(1'($urandom_range(0, 1)), va, $urandom);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // cycle counter picks the calm window and the long receiver hold-off
    int cyc = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        calm <= (cyc > 30000 && cyc < 60000);
    end

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                if (i_in_valid && !o_in_stall) begin
                    expected_replies.push_back(predict_access(pending_words.pop_front()));
                end
                if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= 18)) begin
                    i_in_valid <= 1'b1;
                    i_in_func <= pending_words[0].func;
                    i_in_vaddr <= pending_words[0].vaddr;
                    i_in_write_data <= pending_words[0].wdata;
                end else begin
                    i_in_valid <= 1'b0;
                    if (pending_words.size() == 0) stim_done <= 1'b1;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count = fail_count + 1;
                end else begin
                    e = expected_replies.pop_front();
                    if (o_out_ok !== e.ok) begin
                        $error("ok: expected %0d actual %0d", e.ok, o_out_ok);
                        fail_count = fail_count + 1;
                    end
                    if (o_out_read_data !== e.rdata) begin
                        $error("read_data: expected %h actual %h", e.rdata, o_out_read_data);
                        fail_count = fail_count + 1;
                    end
                end
            end
            // long hold-off once, after the clearing pass, so the input side backs up
            if (cyc == 8000) hold_off <= 3000;
            else if (hold_off > 0) hold_off <= hold_off - 1;
            i_out_stall <= (hold_off > 1) || (!calm && $urandom_range(0, 99) < 18);
        end
    end

    // end of run
    initial begin
        wait (stim_done && !i_in_valid && expected_replies.size() == 0);
        repeat (600) @(posedge i_clk);
        if (fail_count == 0 && expected_replies.size() == 0)
            $display("PASS page_table_walker_with_eviction_top");
        else
            $display("FAIL page_table_walker_with_eviction_top");
        $finish;
    end

    initial begin
        #100ms;
        $display("FAIL page_table_walker_with_eviction_top");
        $finish;
    end
endmodule
